// ----- design/idi_pkg.sv -----
package idi_pkg;

  localparam int unsigned MaxStationsDef = 255;
  localparam int unsigned CoordW = 34;
  localparam int unsigned ValueW = 24;
  localparam int unsigned DistW = 35;
  localparam int unsigned SqW = 70;
  localparam int unsigned SumW = 64;
  localparam int unsigned RadiusW = 20;
  localparam int unsigned CountW = 8;

  localparam logic [2:0] RegRoverX = 3'd0;
  localparam logic [2:0] RegRoverY = 3'd1;
  localparam logic [2:0] RegRoverZ = 3'd2;
  localparam logic [2:0] RegOnlyStatic = 3'd3;
  localparam logic [2:0] RegSnapRadius = 3'd4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusMissing = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,
    StSquare,
    StSqrt,
    StRecip,
    StMulVal,
    StAccum,
    StFinal,
    StDivide,
    StRound,
    StOut
  } state_e;

endpackage

// ----- design/inverse_distance_interpolator_top.sv -----
// Channel   Dir  Handshake                      Words
// s_axis    in   s_axis_tvalid/s_axis_tready    one reference station per word
// m_axis    out  m_axis_tvalid/m_axis_tready    one interpolated result per set
// apb       in   psel/penable/pwrite/pready     rover position, filter, snap radius
//
// Sequence: a counted station keeps s_axis_tready low after its accept while it runs
// the squared distance (diff, then 35 shift-add steps per axis, for all three axes),
// the bit-serial square root, the restoring 2^40/d division, value*w and the
// accumulate step. A skipped station is done in its accept cycle. The last station
// then runs the restoring division for the weighted mean and the rounding step
// before the result word, or goes straight to it on snap, missing value or empty set.
// Reset clears the configuration, the state and the accumulators; s_axis_tready
// stays low while a station is processed or a result is computed or waits.
module inverse_distance_interpolator_top
  import idi_pkg::*;
#(
  parameter int unsigned MaxStations = MaxStationsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: station_x[33:0], station_y[67:34], station_z[101:68],
  //        station_value[125:102], value_present[126], is_static[127]
  input  logic [127:0] s_axis_tdata,
  // tuser: is_rover
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: interp_value[23:0], status[25:24], stations_used[33:26], zero fill
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration
  logic signed [CoordW-1:0] rover_x_q, rover_y_q, rover_z_q;
  logic only_static_q;
  logic [RadiusW-1:0] snap_radius_q;

  logic [2:0] reg_idx;
  logic cfg_wr;
  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_x_q <= '0;
      rover_y_q <= '0;
      rover_z_q <= '0;
      only_static_q <= 1'b0;
      snap_radius_q <= RadiusW'(1000);
    end else if (cfg_wr) begin
      case (reg_idx)
        RegRoverX: rover_x_q <= pwdata[CoordW-1:0];
        RegRoverY: rover_y_q <= pwdata[CoordW-1:0];
        RegRoverZ: rover_z_q <= pwdata[CoordW-1:0];
        RegOnlyStatic: only_static_q <= pwdata[0];
        RegSnapRadius: snap_radius_q <= pwdata[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (reg_idx)
        RegRoverX: prdata = {{(64-CoordW){rover_x_q[CoordW-1]}}, rover_x_q};
        RegRoverY: prdata = {{(64-CoordW){rover_y_q[CoordW-1]}}, rover_y_q};
        RegRoverZ: prdata = {{(64-CoordW){rover_z_q[CoordW-1]}}, rover_z_q};
        RegOnlyStatic: prdata = {63'd0, only_static_q};
        RegSnapRadius: prdata = {44'd0, snap_radius_q};
        default: prdata = '0;
      endcase
    end
  end

  // station latch
  logic signed [CoordW-1:0] sx_q, sy_q, sz_q;
  logic signed [ValueW-1:0] sval_q;
  logic present_q, last_q;

  // sequencer state
  state_e state_q, state_d;
  logic [6:0] cnt_q;
  logic [1:0] axis_q;
  logic [CoordW:0] dabs_q;          // |diff|, 35 bits
  logic [SqW-1:0] sq_q;             // sum of squares, shifted out as sqrt radicand
  logic [SqW-1:0] mulacc_q;         // multiplier accumulator
  logic [DistW:0] root_q;           // root under construction
  logic [SqW-1:0] rem_q;            // shared remainder
  logic [SumW-1:0] quo_q;           // shared quotient
  logic [DistW-1:0] dist_q;
  logic [SumW-1:0] divisor_q;
  logic [SumW+ValueW-1:0] prod_q;   // value*w magnitude

  logic [SumW-1:0] inv_sum_q;
  logic signed [SumW-1:0] wsum_q;
  logic [DistW-1:0] near_d_q;
  logic signed [ValueW-1:0] near_v_q;
  logic [CountW-1:0] count_q;
  logic missing_q;

  logic [ValueW-1:0] res_val_q;
  logic [1:0] res_st_q;
  logic [CountW-1:0] res_cnt_q;
  logic neg_q;

  logic accept;
  logic counted;
  assign s_axis_tready = (state_q == StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign counted = !s_axis_tuser && (!only_static_q || s_axis_tdata[127])
                   && (32'(count_q) < MaxStations);

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = {6'd0, res_cnt_q, res_st_q, res_val_q};

  // shared datapath terms
  logic signed [CoordW:0] diff;
  logic signed [CoordW-1:0] sel_s, sel_r;
  logic [SqW-1:0] trial;
  logic [SqW:0] rem_shift;
  logic [SumW:0] sub_res;

  always_comb begin
    case (axis_q)
      2'd0: begin sel_s = sx_q; sel_r = rover_x_q; end
      2'd1: begin sel_s = sy_q; sel_r = rover_y_q; end
      default: begin sel_s = sz_q; sel_r = rover_z_q; end
    endcase
    diff = (CoordW+1)'(sel_r) - (CoordW+1)'(sel_s);
    // sqrt trial: 4*root + 1, the bit position handled by shifting the remainder
    trial = SqW'({root_q[DistW-1:0], 2'b01});
    // next dividend bit comes out of the top of the quotient register
    rem_shift = {rem_q, quo_q[SumW-1]};
    sub_res = rem_shift[SumW:0] - {1'b0, divisor_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept) state_d = counted ? StDiff : (s_axis_tlast ? StFinal : StIdle);
      StDiff: state_d = StSquare;
      StSquare: if (cnt_q == 7'd0) state_d = (axis_q == 2'd2) ? StSqrt : StDiff;
      StSqrt: if (cnt_q == 7'd0) state_d = StRecip;
      StRecip: if (cnt_q == 7'd0) state_d = StMulVal;
      StMulVal: if (cnt_q == 7'd0) state_d = StAccum;
      StAccum: state_d = last_q ? StFinal : StIdle;
      StFinal: state_d = (count_q == '0 || missing_q || near_d_q < DistW'(snap_radius_q))
                         ? StOut : StDivide;
      StDivide: if (cnt_q == 7'd0) state_d = StRound;
      StRound: state_d = StOut;
      StOut: if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      inv_sum_q <= '0;
      wsum_q <= '0;
      near_d_q <= '1;
      near_v_q <= '0;
      count_q <= '0;
      missing_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StAccum) begin
        logic [SumW:0] isum;
        logic signed [SumW+ValueW:0] ws, p;
        isum = {1'b0, inv_sum_q} + {1'b0, quo_q};
        inv_sum_q <= isum[SumW] ? '1 : isum[SumW-1:0];
        if (present_q) begin
          p = sval_q[ValueW-1] ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
          ws = (SumW+ValueW+1)'(wsum_q) + p;
          if (ws > (SumW+ValueW+1)'(64'sh7FFF_FFFF_FFFF_FFFF))
            wsum_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (ws < (SumW+ValueW+1)'(64'sh8000_0000_0000_0000))
            wsum_q <= 64'sh8000_0000_0000_0000;
          else
            wsum_q <= ws[SumW-1:0];
        end else begin
          missing_q <= 1'b1;
        end
        if (dist_q < near_d_q) begin
          near_d_q <= dist_q;
          near_v_q <= sval_q;
        end
        if (count_q != '1) count_q <= count_q + 1'b1;
      end
      if (state_q == StOut && m_axis_tready) begin
        inv_sum_q <= '0;
        wsum_q <= '0;
        near_d_q <= '1;
        near_v_q <= '0;
        count_q <= '0;
        missing_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          sx_q <= s_axis_tdata[33:0];
          sy_q <= s_axis_tdata[67:34];
          sz_q <= s_axis_tdata[101:68];
          sval_q <= s_axis_tdata[125:102];
          present_q <= s_axis_tdata[126];
          last_q <= s_axis_tlast;
          axis_q <= 2'd0;
          sq_q <= '0;
        end
      end
      StDiff: begin
        dabs_q <= diff[CoordW] ? (CoordW+1)'(-diff) : (CoordW+1)'(diff);
        mulacc_q <= '0;
        cnt_q <= 7'(DistW - 1);
      end
      StSquare: begin
        // shift-add multiply, MSB first, one bit per cycle
        logic [SqW-1:0] acc;
        acc = {mulacc_q[SqW-2:0], 1'b0};
        if (dabs_q[cnt_q[5:0]]) acc = acc + SqW'(dabs_q);
        mulacc_q <= acc;
        if (cnt_q == 7'd0) begin
          sq_q <= sq_q + acc;
          axis_q <= axis_q + 2'd1;
          root_q <= '0;
          rem_q <= '0;
          cnt_q <= 7'(DistW - 1);
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StSqrt: begin
        // digit-by-digit root, two radicand bits per step
        logic [SqW-1:0] r2;
        logic fit;
        r2 = {rem_q[SqW-3:0], sq_q[SqW-1 -: 2]};
        fit = (r2 >= trial);
        sq_q <= {sq_q[SqW-3:0], 2'b00};
        root_q <= {root_q[DistW-1:0], fit};
        if (cnt_q == 7'd0) begin
          dist_q <= {root_q[DistW-2:0], fit};
          divisor_q <= (fit || root_q[DistW-2:0] != '0)
                       ? SumW'({root_q[DistW-2:0], fit}) : SumW'(1);
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 7'd40;
        end else begin
          rem_q <= fit ? r2 - trial : r2;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StRecip: begin
        // restoring divide of 2^40: dividend is one bit at the top
        logic [SumW:0] rs, sb;
        rs = {rem_q[SumW-1:0], (cnt_q == 7'd40)};
        sb = rs - {1'b0, divisor_q};
        if (!sb[SumW]) begin
          rem_q <= SqW'(sb[SumW-1:0]);
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= SqW'(rs[SumW-1:0]);
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
        if (cnt_q == 7'd0) begin
          prod_q <= '0;
          cnt_q <= 7'(ValueW - 1);
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
      StMulVal: begin
        logic [ValueW-1:0] mag;
        logic [SumW+ValueW-1:0] pa;
        mag = sval_q[ValueW-1] ? ValueW'(-sval_q) : ValueW'(sval_q);
        pa = {prod_q[SumW+ValueW-2:0], 1'b0};
        if (mag[cnt_q[4:0]]) pa = pa + (SumW+ValueW)'(quo_q);
        prod_q <= pa;
        if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
      end
      StFinal: begin
        res_cnt_q <= count_q;
        if (count_q == '0) begin
          res_st_q <= StatusEmpty;
          res_val_q <= '0;
        end else if (missing_q) begin
          res_st_q <= StatusMissing;
          res_val_q <= '0;
        end else begin
          res_st_q <= StatusOk;
          res_val_q <= (near_d_q < DistW'(snap_radius_q)) ? near_v_q : '0;
        end
        neg_q <= wsum_q[SumW-1];
        quo_q <= wsum_q[SumW-1] ? SumW'(-wsum_q) : SumW'(wsum_q);
        divisor_q <= inv_sum_q;
        rem_q <= '0;
        cnt_q <= 7'(SumW - 1);
      end
      StDivide: begin
        // quotient shifts in where dividend shifts out
        if (!sub_res[SumW]) begin
          rem_q <= SqW'(sub_res[SumW-1:0]);
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= SqW'(rem_shift[SumW-1:0]);
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
        if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
      end
      StRound: begin
        logic [SumW:0] qq;
        logic [SumW:0] rr2;
        rr2 = {rem_q[SumW-1:0], 1'b0};
        qq = {1'b0, quo_q} + ((rr2 >= {1'b0, divisor_q}) ? 65'd1 : 65'd0);
        if (qq > 65'd8388608) qq = 65'd8388608;
        if (neg_q) res_val_q <= ValueW'(-qq[ValueW:0]);
        else res_val_q <= (qq > 65'd8388607) ? 24'h7FFFFF : qq[ValueW-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- bench/idi_checker.sv -----
module idi_checker
  import idi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [39:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ValueW-1:0] interp;
    logic [1:0]        status;
    logic [CountW-1:0] used;
  } result_t;

  // register shadow
  logic signed [CoordW-1:0] rov_x, rov_y, rov_z;
  logic                     static_only;
  logic [RadiusW-1:0]       snap_mm;

  // set accumulators
  logic [63:0]        wsum_inv;
  logic signed [63:0] wsum_val;
  logic [DistW-1:0]   near_d;
  logic [ValueW-1:0]  near_val;
  int unsigned        n_used;
  logic               saw_missing;

  result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [63:0] abs_diff(logic signed [CoordW-1:0] a,
                                           logic signed [CoordW-1:0] b);
    longint dd;
    dd = longint'(a) - longint'(b);
    return (dd < 0) ? 64'(-dd) : 64'(dd);
  endfunction

  function automatic logic [DistW-1:0] dist_mm(logic [127:0] w);
    logic [127:0] sq, t2, ax;
    logic [35:0]  r, t;
    sq = '0;
    ax = {64'd0, abs_diff(rov_x, w[33:0])};   sq += ax * ax;
    ax = {64'd0, abs_diff(rov_y, w[67:34])};  sq += ax * ax;
    ax = {64'd0, abs_diff(rov_z, w[101:68])}; sq += ax * ax;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      t2 = {92'd0, t} * {92'd0, t};
      if (t2 <= sq) r = t;
    end
    return r[DistW-1:0];
  endfunction

  task automatic clear_set();
    wsum_inv = '0;
    wsum_val = '0;
    near_d = '1;
    near_val = '0;
    n_used = 0;
    saw_missing = 1'b0;
  endtask

  task automatic take_station(logic [127:0] w, logic rover, logic last);
    logic [DistW-1:0]    d;
    logic [63:0]         wt, mag, qq, rr;
    logic [64:0]         inv_next;
    logic signed [127:0] vs, ws, acc;
    logic                present, is_stat;
    longint              q;
    result_t             res;
    present = w[126];
    is_stat = w[127];
    if (!rover && (!static_only || is_stat) && n_used < MaxStationsDef) begin
      d = dist_mm(w);
      wt = (64'd1 << 40) / ((d == 0) ? 64'd1 : 64'(d));
      inv_next = {1'b0, wsum_inv} + {1'b0, wt};
      wsum_inv = inv_next[64] ? '1 : inv_next[63:0];
      if (present) begin
        vs = $signed(w[125:102]);
        ws = $signed({64'd0, wt});
        acc = $signed(wsum_val) + vs * ws;
        if (acc > 128'sh7FFF_FFFF_FFFF_FFFF) wsum_val = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (acc < -128'sh8000_0000_0000_0000) wsum_val = 64'sh8000_0000_0000_0000;
        else wsum_val = acc[63:0];
      end else begin
        saw_missing = 1'b1;
      end
      if (d < near_d) begin
        near_d = d;
        near_val = w[125:102];
      end
      if (n_used < 255) n_used++;
    end
    if (!last) return;
    res.used = n_used[7:0];
    q = 0;
    if (n_used == 0) res.status = StatusEmpty;
    else if (saw_missing) res.status = StatusMissing;
    else begin
      res.status = StatusOk;
      if (near_d < DistW'(snap_mm)) begin
        q = longint'($signed(near_val));
      end else begin
        mag = (wsum_val < 0) ? 64'(-wsum_val) : 64'(wsum_val);
        qq = mag / wsum_inv;
        rr = mag % wsum_inv;
        if (rr >= wsum_inv - rr) qq++;
        if (qq > 64'd8388608) qq = 64'd8388608;
        q = (wsum_val < 0) ? -longint'(qq) : longint'(qq);
        if (q > 8388607) q = 8388607;
      end
    end
    res.interp = q[ValueW-1:0];
    result_q = {result_q, res};
    clear_set();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_r;
    if (!rst_ni) begin
      rov_x <= '0; rov_y <= '0; rov_z <= '0;
      static_only <= 1'b0;
      snap_mm <= RadiusW'(1000);
      clear_set();
      fail_count <= 0;
    end else begin
      // result first: it always belongs to an earlier station word
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[23:0], m_axis_tdata[25:24], m_axis_tdata[33:26]};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word, got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got.interp !== exp_r.interp)
            $display("%0t: interp_value expected %0d got %0d", $time,
                     $signed(exp_r.interp), $signed(got.interp));
          if (got.status !== exp_r.status)
            $display("%0t: status expected %0d got %0d", $time,
                     exp_r.status, got.status);
          if (got.used !== exp_r.used)
            $display("%0t: stations_used expected %0d got %0d", $time,
                     exp_r.used, got.used);
          if (got !== exp_r) fail_count <= fail_count + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        take_station(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegRoverX:     rov_x <= pwdata[33:0];
          RegRoverY:     rov_y <= pwdata[33:0];
          RegRoverZ:     rov_z <= pwdata[33:0];
          RegOnlyStatic: static_only <= pwdata[0];
          RegSnapRadius: snap_mm <= pwdata[RadiusW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/tb_inverse_distance_interpolator_top.sv -----
module tb_inverse_distance_interpolator_top;
  import idi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  int fail_count;
  int pending;

  // shared knobs: quiet turns idling off on both sides; each stall ticket
  // asks the receiver for one long hold-off
  bit quiet = 1'b0;
  int stall_tickets = 0;

  // rover position of the current phase, used to place stations nearby
  longint rx, ry, rz;

  localparam longint CMax = 64'sd8589934591;
  localparam longint CMin = -64'sd8589934592;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  inverse_distance_interpolator_top dut (.*);

  idi_checker chk (.*);

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random back-pressure plus long hold-offs on request
  initial begin
    int served, hold;
    served = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && served != stall_tickets) begin
        served++;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // block idle: all results in, plus room for a skipped or trailing station
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_rover(longint x, longint y, longint z, bit st, int snap);
    rx = x; ry = y; rz = z;
    reg_write(RegRoverX, 64'(x));
    reg_write(RegRoverY, 64'(y));
    reg_write(RegRoverZ, 64'(z));
    reg_write(RegOnlyStatic, 64'(st));
    reg_write(RegSnapRadius, 64'(snap));
  endtask

  task automatic send_word(longint x, longint y, longint z, int val,
                           bit present, bit st, bit rover, bit last);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {st, present, val[23:0], z[33:0], y[33:0], x[33:0]};
    s_axis_tuser <= rover;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic longint clamp34(longint v);
    return (v > CMax) ? CMax : (v < CMin) ? CMin : v;
  endfunction

  function automatic longint rand_coord();
    return longint'({$urandom, $urandom}) >>> 30;
  endfunction

  // station offset from the rover: mostly local, sometimes anywhere
  function automatic longint near(longint c);
    case ($urandom_range(9))
      0:       return rand_coord();
      1:       return c + $urandom_range(0, 1200) - 600;
      2, 3:    return clamp34(c + longint'($urandom_range(0, 1 << 30)) - (1 << 29));
      default: return clamp34(c + longint'($urandom_range(0, 4000000)) - 2000000);
    endcase
  endfunction

  function automatic int rand_value();
    case ($urandom_range(9))
      0:       return -8388608;
      1:       return 8388607;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  task automatic random_station(bit last);
    send_word(near(rx), near(ry), near(rz), rand_value(),
              $urandom_range(99) < 92, $urandom_range(99) < 70,
              $urandom_range(99) < 8, last);
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset-default registers first, station on the rover (snap)
    rx = 0; ry = 0; rz = 0;
    send_word(0, 0, 0, 1234, 1, 1, 0, 1);
    // rover word only: nothing counted
    send_word(5, 5, 5, 77, 1, 1, 1, 1);
    // missing value among good ones
    send_word(100000, 0, 0, 50, 1, 0, 0, 0);
    send_word(0, 200000, 0, 60, 0, 1, 0, 1);
    // tie at equal distance: first one wins the snap
    drain();
    reg_write(RegSnapRadius, 64'd1000000);
    send_word(500, 0, 0, -111, 1, 1, 0, 0);
    send_word(-500, 0, 0, 222, 1, 1, 0, 1);
    // coordinate extremes, rover at the opposite corner
    drain();
    set_rover(CMin, CMin, CMin, 1'b0, 0);
    send_word(CMax, CMax, CMax, 8388607, 1, 1, 0, 0);
    send_word(CMin, CMax, CMin, -8388608, 1, 0, 0, 1);
    // saturation of the weighted sum: two stations at zero distance
    drain();
    set_rover(CMax, CMax, CMax, 1'b0, 0);
    send_word(CMax, CMax, CMax, 8388607, 1, 1, 0, 0);
    send_word(CMax, CMax, CMax - 1, 8388607, 1, 1, 0, 0);
    send_word(CMax - 1, CMax, CMax, -3, 1, 1, 0, 1);
    send_word(CMax, CMax, CMax, -8388608, 1, 1, 0, 0);
    send_word(CMax, CMax, CMax, -8388608, 1, 1, 0, 1);
    // static filter: non-static and rover dropped, then empty set
    drain();
    set_rover(0, 0, 0, 1'b1, 1000);
    send_word(3000, 0, 0, 40, 1, 0, 0, 0);
    send_word(0, 4000, 0, 80, 1, 1, 0, 0);
    send_word(0, 0, 5000, 90, 1, 1, 1, 1);
    send_word(7000, 0, 0, 10, 1, 0, 0, 1);

    // station limit: more than 255 counted stations in one set
    drain();
    set_rover(rand_coord(), rand_coord(), rand_coord(), 1'b0, 20000);
    quiet = 1'b1;
    for (int i = 0; i < 262; i++)
      send_word(near(rx), near(ry), near(rz), rand_value(), 1, 1, 0, i == 261);
    quiet = 1'b0;

    // random phases, each with fresh registers
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: set_rover(CMax, CMin, 0, 1'b0, 1000000);
        1: set_rover(0, 0, 0, 1'b1, 0);
        default: set_rover(rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(1), $urandom_range(0, 1000000));
      endcase
      quiet = (ph == 4);
      n = 0;
      while (n < 100) begin
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) random_station(k == len - 1);
        n += len;
        // a long receiver hold-off early in phase 2 while stations keep coming
        if (ph == 2 && n < 10) stall_tickets++;
        if ($urandom_range(30) == 0) begin
          @(negedge clk_i);
          s_axis_tvalid <= 1'b0;
          wait (pending == 0);
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/idi_pkg.sv
design/inverse_distance_interpolator_top.sv
bench/idi_checker.sv
bench/tb_inverse_distance_interpolator_top.sv
